FILE: rtl/core/whac_pkg.sv
`default_nettype none

package whac_pkg;

    localparam int NBINS_W   = 9;
    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 32;
    localparam int CONTENT_W = 48;
    localparam int SUM_W     = 64;
    localparam int REQ_W     = 3;

    // Index that addresses the overflow bin on purpose
    localparam logic signed [INDEX_W-1:0] INDEX_OVERFLOW = -10'sd1;

    localparam logic [CONTENT_W-1:0] CONTENT_MAX = {1'b0, {(CONTENT_W-1){1'b1}}};
    localparam logic [CONTENT_W-1:0] CONTENT_MIN = {1'b1, {(CONTENT_W-1){1'b0}}};

    typedef enum logic [REQ_W-1:0] {
        REQ_FILL        = 3'd0,
        REQ_SET_CONTENT = 3'd1,
        REQ_SET_ERROR   = 3'd2,
        REQ_READ        = 3'd3,
        REQ_CLEAR       = 3'd4
    } req_t;

    typedef struct packed {
        logic                 content_we;
        logic                 sum_we;
        logic [CONTENT_W-1:0] content;
        logic [SUM_W-1:0]     sum;
    } upd_t;

endpackage

`default_nettype wire

FILE: rtl/core/whac_update.sv
`default_nettype none

module whac_update (
    input  whac_pkg::req_t                           req,
    input  logic signed [whac_pkg::VALUE_W-1:0]      value,
    input  logic [whac_pkg::SUM_W-1:0]               square,
    input  logic signed [whac_pkg::CONTENT_W-1:0]    old_content,
    input  logic [whac_pkg::SUM_W-1:0]               old_sum,
    output whac_pkg::upd_t                           upd
);
    import whac_pkg::*;

    logic signed [CONTENT_W:0] csum;
    logic [SUM_W:0]            ssum;
    logic [CONTENT_W-1:0]      csat;
    logic [SUM_W-1:0]          ssat;

    assign csum = (CONTENT_W+1)'(old_content) + (CONTENT_W+1)'(value);
    assign ssum = {1'b0, old_sum} + {1'b0, square};

    // two's-complement overflow shows as a mismatch of the top two bits
    assign csat = (csum[CONTENT_W] != csum[CONTENT_W-1])
                ? (csum[CONTENT_W] ? CONTENT_MIN : CONTENT_MAX)
                : csum[CONTENT_W-1:0];
    assign ssat = ssum[SUM_W] ? {SUM_W{1'b1}} : ssum[SUM_W-1:0];

    always_comb
    begin
        upd.content_we = 1'b0;
        upd.sum_we     = 1'b0;
        upd.content    = old_content;
        upd.sum        = old_sum;
        case (req)
            REQ_FILL:
            begin
                upd.content_we = 1'b1;
                upd.sum_we     = 1'b1;
                upd.content    = csat;
                upd.sum        = ssat;
            end
            REQ_SET_CONTENT:
            begin
                upd.content_we = 1'b1;
                upd.content    = CONTENT_W'(value);
            end
            REQ_SET_ERROR:
            begin
                upd.sum_we = 1'b1;
                upd.sum    = square;
            end
            default:
            begin
                upd.content_we = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/weighted_histogram_accumulator_unit.sv
`default_nettype none

// Weighted histogram with a saturating content (Q32.16) and sum of squared
// weights (Q32.32) per bin, kept in two single-port synchronous memories of
// MAX_BINS+1 entries. Fill, set content, set error and read each run as a
// memory read (the weight is squared alongside), then the saturating
// update, write-back and load of the output register, which waits while the
// output is held; a new beat is taken only once the last result is loaded.
// Unknown request codes answer with zeros. Clear all sweeps the memories
// one entry a cycle through all MAX_BINS+1 entries, then answers with zeros.
// The same sweep runs after reset: no beat is taken until it is done.
// num_bins may be written at any time the unit is idle.
module weighted_histogram_accumulator_unit #(
    parameter int MAX_BINS = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [whac_pkg::NBINS_W-1:0]    cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [47:0]                     s_tdata,   // bin_index[9:0], value[41:10]
    input  wire logic [whac_pkg::REQ_W-1:0]      s_tuser,   // req_type[2:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [111:0]                         m_tdata,   // content[47:0], sum_squares[111:48]
    output logic                                 m_tuser    // redirected[0]
);
    import whac_pkg::*;

    localparam int DEPTH = MAX_BINS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (AW > NBINS_W) ? AW : NBINS_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ZERO
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           clr_addr_reg, clr_addr_next;
    logic                    clr_resp_reg, clr_resp_next;
    logic [NBINS_W-1:0]      num_bins_reg;
    req_t                    req_reg, req_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [SUM_W-1:0]        sq_reg, sq_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic                    redir_reg, redir_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [CONTENT_W-1:0]    m_content_reg, m_content_next;
    logic [SUM_W-1:0]        m_sum_reg, m_sum_next;
    logic                    m_redir_reg, m_redir_next;

    logic [CONTENT_W-1:0]    content_mem [DEPTH];
    logic [SUM_W-1:0]        sum_mem [DEPTH];
    logic [CONTENT_W-1:0]    content_rd_reg;
    logic [SUM_W-1:0]        sum_rd_reg;

    logic                    s_accept;
    req_t                    in_req;
    logic signed [INDEX_W-1:0] in_index;
    logic signed [VALUE_W-1:0] in_value;
    logic [VALUE_W-1:0]      in_mag;
    logic [SUM_W-1:0]        in_square;
    logic [CW-1:0]           nb;
    logic [CW-1:0]           idx_mag;
    logic [CW-1:0]           bin;
    logic                    in_redir;
    logic                    out_free;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [CONTENT_W-1:0]    mem_wcontent;
    logic [SUM_W-1:0]        mem_wsum;
    logic                    content_we;
    logic                    sum_we;
    upd_t                    upd;

    assign in_req   = req_t'(s_tuser);
    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W +: VALUE_W];
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // most negative weight has no positive twin; its magnitude still fits unsigned
    assign in_mag    = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
    assign in_square = SUM_W'(in_mag) * SUM_W'(in_mag);

    always_comb
    begin
        nb = (CW'(num_bins_reg) > CW'(MAX_BINS)) ? CW'(MAX_BINS) : CW'(num_bins_reg);
        idx_mag  = CW'(in_index[INDEX_W-2:0]);
        in_redir = 1'b0;
        bin      = idx_mag;
        if (in_index == INDEX_OVERFLOW)
        begin
            bin = nb;
        end
        else if (in_index[INDEX_W-1] || (idx_mag > nb))
        begin
            bin      = nb;
            in_redir = 1'b1;
        end
    end

    whac_update u_update (
        .req         (req_reg),
        .value       (value_reg),
        .square      (sq_reg),
        .old_content (content_rd_reg),
        .old_sum     (sum_rd_reg),
        .upd         (upd)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_resp_next  = clr_resp_reg;
        req_next       = req_reg;
        value_next     = value_reg;
        sq_next        = sq_reg;
        addr_next      = addr_reg;
        redir_next     = redir_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_content_next = m_content_reg;
        m_sum_next     = m_sum_reg;
        m_redir_next   = m_redir_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(MAX_BINS))
                begin
                    clr_addr_next = '0;
                    state_next    = clr_resp_reg ? S_ZERO : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_accept)
                begin
                    req_next   = in_req;
                    value_next = in_value;
                    sq_next    = in_square;
                    addr_next  = bin[AW-1:0];
                    redir_next = in_redir;
                    case (in_req)
                        REQ_FILL, REQ_SET_CONTENT, REQ_SET_ERROR, REQ_READ:
                        begin
                            state_next = S_EXEC;
                        end
                        REQ_CLEAR:
                        begin
                            clr_addr_next = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_ZERO;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    m_content_next = upd.content;
                    m_sum_next     = upd.sum;
                    m_redir_next   = redir_reg;
                    state_next     = S_IDLE;
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    m_content_next = '0;
                    m_sum_next     = '0;
                    m_redir_next   = 1'b0;
                    clr_resp_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            clr_resp_reg  <= 1'b0;
            num_bins_reg  <= NBINS_W'(256);
            req_reg       <= REQ_READ;
            value_reg     <= '0;
            sq_reg        <= '0;
            addr_reg      <= '0;
            redir_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_content_reg <= '0;
            m_sum_reg     <= '0;
            m_redir_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_resp_reg  <= clr_resp_next;
            if (cfg_we)
            begin
                num_bins_reg <= cfg_wdata;
            end
            req_reg       <= req_next;
            value_reg     <= value_next;
            sq_reg        <= sq_next;
            addr_reg      <= addr_next;
            redir_reg     <= redir_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_content_reg <= m_content_next;
            m_sum_reg     <= m_sum_next;
            m_redir_reg   <= m_redir_next;
        end
    end

    // write port: sweep during clear, update when the result is loaded into the output register
    always_comb
    begin
        mem_we       = 1'b0;
        content_we   = 1'b0;
        sum_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wcontent = upd.content;
        mem_wsum     = upd.sum;
        if (state_reg == S_CLEAR)
        begin
            mem_we       = 1'b1;
            content_we   = 1'b1;
            sum_we       = 1'b1;
            mem_waddr    = clr_addr_reg;
            mem_wcontent = '0;
            mem_wsum     = '0;
        end
        else if ((state_reg == S_EXEC) && out_free)
        begin
            mem_we     = upd.content_we || upd.sum_we;
            content_we = upd.content_we;
            sum_we     = upd.sum_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we && content_we)
        begin
            content_mem[mem_waddr] <= mem_wcontent;
        end
        if (s_accept)
        begin
            content_rd_reg <= content_mem[bin[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we && sum_we)
        begin
            sum_mem[mem_waddr] <= mem_wsum;
        end
        if (s_accept)
        begin
            sum_rd_reg <= sum_mem[bin[AW-1:0]];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_sum_reg, m_content_reg};
    assign m_tuser  = m_redir_reg;

    // a fill never lowers the sum of squares
    a_fill_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && (req_reg == REQ_FILL) |-> (upd.sum >= sum_rd_reg))
        else $error("fill lowered the sum of squares");

    // the resolved bin always lies inside the memory
    a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> (addr_reg <= AW'(MAX_BINS)))
        else $error("bin address beyond the overflow bin");

    // a clear beat starts a full sweep from entry zero
    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (in_req == REQ_CLEAR) |=> (state_reg == S_CLEAR) && (clr_addr_reg == '0))
        else $error("clear did not start a sweep at entry zero");

    // the sweep steps through consecutive entries
    a_sweep_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) && (clr_addr_reg != AW'(MAX_BINS)) |=>
        (state_reg == S_CLEAR) && (clr_addr_reg == $past(clr_addr_reg) + 1'b1))
        else $error("clear sweep skipped or stopped early");

endmodule

`default_nettype wire

FILE: bench/tb_weighted_histogram_accumulator_unit.sv
module tb_weighted_histogram_accumulator_unit;

    import whac_pkg::*;

    localparam int HIST_BINS         = 256;
    localparam int STALL_LIMIT       = 3000;
    localparam int SINK_HOLD_CYCLES  = 300;
    localparam int ITEMS_PER_PHASE   = 112;
    localparam int BURST_FILLS       = 16;

    localparam logic signed [31:0] W_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] W_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] W_UNIT = 32'sh0001_0000;

    localparam logic signed [63:0] ACC_MAX = (64'sd1 <<< (CONTENT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] ACC_MIN = -ACC_MAX - 64'sd1;

    typedef struct packed {
        logic [CONTENT_W-1:0] content;
        logic [SUM_W-1:0]     sum;
        logic                 redir;
    } bin_result_t;

    class bin_store_model;
        logic signed [CONTENT_W-1:0] content_mem [0:HIST_BINS];
        logic [SUM_W-1:0]            square_mem  [0:HIST_BINS];
        logic [NBINS_W-1:0]          bin_count;
        bin_result_t                 pending_bins [$];
        int unsigned                 mismatches;

        function new();
            bin_count  = NBINS_W'(HIST_BINS);
            mismatches = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (content_mem[i])
            begin
                content_mem[i] = '0;
                square_mem[i]  = '0;
            end
        endfunction

        function void set_bin_count(logic [NBINS_W-1:0] n);
            bin_count = n;
        endfunction

        function int effective_bins();
            return (int'(bin_count) > HIST_BINS) ? HIST_BINS : int'(bin_count);
        endfunction

        function logic [SUM_W-1:0] square_of(logic signed [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] m;
            m = v[VALUE_W-1] ? 32'd0 - v : v;
            return {32'd0, m} * {32'd0, m};
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic signed [INDEX_W-1:0] idx,
                                   logic signed [VALUE_W-1:0] val);
            int                eff;
            int                target;
            logic              flag;
            logic signed [63:0] acc;
            logic [SUM_W:0]    total;
            bin_result_t       res;
            res  = '0;
            flag = 1'b0;
            if (req == REQ_CLEAR)
            begin
                wipe();
                pending_bins = {pending_bins, res};
                return;
            end
            // reserved codes answer with zeros and touch nothing
            if (req > REQ_CLEAR)
            begin
                pending_bins = {pending_bins, res};
                return;
            end
            eff = effective_bins();
            if (idx == INDEX_OVERFLOW)
                target = eff;
            else if (idx < 0 || int'(idx) > eff)
            begin
                target = eff;
                flag   = 1'b1;
            end
            else
                target = int'(idx);
            case (req)
                REQ_FILL:
                begin
                    acc = content_mem[target];
                    acc = acc + val;
                    if (acc > ACC_MAX)
                        acc = ACC_MAX;
                    if (acc < ACC_MIN)
                        acc = ACC_MIN;
                    content_mem[target] = acc[CONTENT_W-1:0];
                    total = {1'b0, square_mem[target]} + {1'b0, square_of(val)};
                    square_mem[target] = total[SUM_W] ? '1 : total[SUM_W-1:0];
                end
                REQ_SET_CONTENT: content_mem[target] = val;
                REQ_SET_ERROR:   square_mem[target]  = square_of(val);
                default: ;
            endcase
            res.content = content_mem[target];
            res.sum     = square_mem[target];
            res.redir   = flag;
            pending_bins = {pending_bins, res};
        endfunction

        function void check_result(logic [CONTENT_W-1:0] c, logic [SUM_W-1:0] s, logic r);
            bin_result_t want;
            if (pending_bins.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: content %h sum %h redirected %b", c, s, r);
                return;
            end
            want = pending_bins.pop_front();
            if (want.content !== c || want.sum !== s || want.redir !== r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("bin mismatch: exp %h %h %b, got %h %h %b",
                             want.content, want.sum, want.redir, c, s, r);
            end
        endfunction

        function int outstanding();
            return pending_bins.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [NBINS_W-1:0]     cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [47:0]            s_tdata;    // bin_index[9:0], value[41:10]
    logic [REQ_W-1:0]       s_tuser;    // req_type[2:0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [111:0]           m_tdata;    // content[47:0], sum_squares[111:48]
    logic                   m_tuser;    // redirected[0]

    logic src_idling  = 1'b1;
    logic sink_idling = 1'b1;
    logic sink_hold   = 1'b0;

    logic [NBINS_W-1:0] phase_bins [8] = '{9'd0, 9'd1, 9'd511, 9'd2, 9'd255, 9'd256, 9'd300,
                                          9'd128};

    bin_store_model model;

    always #1 clk = ~clk;

    weighted_histogram_accumulator_unit #(
        .MAX_BINS (HIST_BINS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    task automatic send_request(logic [REQ_W-1:0] req, logic signed [INDEX_W-1:0] idx,
                                logic signed [VALUE_W-1:0] val);
        @(negedge clk);
        while (src_idling && $urandom_range(99) < 29)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, val, idx};
        s_tuser  = req;
        do
            @(posedge clk);
        while (!s_tready);
        model.note_request(req, idx, val);
    endtask

    // register writes only once the unit has drained
    task automatic set_bin_count(logic [NBINS_W-1:0] n);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (model.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = n;
        @(negedge clk);
        cfg_we = 1'b0;
        model.set_bin_count(n);
    endtask

    task automatic send_random_request();
        int                        eff;
        int                        pick;
        logic [REQ_W-1:0]          req;
        logic signed [INDEX_W-1:0] idx;
        logic signed [VALUE_W-1:0] val;
        eff  = model.effective_bins();
        pick = $urandom_range(99);
        if (pick < 58)
            req = REQ_FILL;
        else if (pick < 68)
            req = REQ_SET_CONTENT;
        else if (pick < 76)
            req = REQ_SET_ERROR;
        else if (pick < 90)
            req = REQ_READ;
        else if (pick < 93)
            req = REQ_CLEAR;
        else
            req = REQ_W'(int'(REQ_CLEAR) + 1 + $urandom_range(2));
        case ($urandom_range(9))
            0:       idx = INDEX_OVERFLOW;
            1:       idx = INDEX_W'(eff + 1 + $urandom_range(4));
            2:       idx = INDEX_W'($urandom);
            3:       idx = INDEX_W'(eff);
            default: idx = INDEX_W'($urandom_range(eff));
        endcase
        case ($urandom_range(9))
            0:       val = W_MAX;
            1:       val = W_MIN;
            2:       val = '0;
            3:       val = -32'sd1;
            4, 5:    val = 32'($signed(20'($urandom)));
            default: val = 32'($urandom);
        endcase
        send_request(req, idx, val);
    endtask

    // result side: random back-pressure plus one long hold on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold)
            begin
                m_tready = 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge clk);
                sink_hold = 1'b0;
            end
            m_tready = !(sink_idling && $urandom_range(99) < 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            model.check_result(m_tdata[47:0], m_tdata[111:48], m_tuser);
    end

    initial
    begin
        int stall;
        stall = 0;
        wait (rst_n === 1'b1);
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall = 0;
            else
                stall++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        model     = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extreme weights drive the sum of squares into saturation
        send_request(REQ_FILL, 10'sd0, W_MAX);
        repeat (4) send_request(REQ_FILL, 10'sd0, W_MIN);
        send_request(REQ_READ, 10'sd0, '0);
        // index equal to the bin count and minus one both address the overflow bin, unflagged
        send_request(REQ_SET_CONTENT, 10'sd256, 32'sh1234_5678);
        send_request(REQ_SET_ERROR, INDEX_OVERFLOW, W_MIN);
        send_request(REQ_READ, INDEX_OVERFLOW, '0);
        send_request(REQ_FILL, -10'sd512, W_UNIT);
        send_request(REQ_FILL, 10'sd511, -32'sd1);
        send_request(REQ_FILL, 10'sd257, W_UNIT);
        send_request(REQ_SET_CONTENT, 10'sd255, -32'sd1);
        send_request(REQ_SET_ERROR, 10'sd255, W_MAX);
        send_request(REQ_READ, 10'sd255, '0);
        for (int k = int'(REQ_CLEAR) + 1; k < 8; k++)
            send_request(REQ_W'(k), 10'sd3, W_MAX);
        send_request(REQ_CLEAR, 10'sd7, W_MAX);
        send_request(REQ_READ, 10'sd0, '0);
        send_request(REQ_READ, INDEX_OVERFLOW, '0);
        send_request(REQ_FILL, 10'sd1, '0);

        // burst of extreme weights, no idling on either side
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        repeat (BURST_FILLS) send_request(REQ_FILL, 10'sd2, W_MAX);
        send_request(REQ_SET_CONTENT, 10'sd3, W_MIN);
        repeat (BURST_FILLS) send_request(REQ_FILL, 10'sd3, W_MIN);
        src_idling  = 1'b1;
        sink_idling = 1'b1;

        for (int p = 0; p < 8; p++)
        begin
            set_bin_count(phase_bins[p]);
            if (p == 3)
                sink_hold = 1'b1;
            src_idling  = (p != 5);
            sink_idling = (p != 5);
            repeat (ITEMS_PER_PHASE) send_random_request();
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (model.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (model.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: weighted_histogram_accumulator_unit.f
rtl/core/whac_pkg.sv
rtl/core/whac_update.sv
rtl/core/weighted_histogram_accumulator_unit.sv
bench/tb_weighted_histogram_accumulator_unit.sv
